FILE: hw/rtl/ftrc_pkg.sv
// ----------------------------------------------------------------------------
// ftrc_pkg
// Shared types and constants of the file transfer request checker.
// ----------------------------------------------------------------------------
package ftrc_pkg;

  // Status codes of a judged request
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_LENGTH   = 3'd1,
    ST_RANGE    = 3'd2,
    ST_SESSION  = 3'd3,
    ST_SECURITY = 3'd4
  } status_t;

  // Request limits
  localparam int unsigned NAME_CAPACITY      = 64;
  localparam int unsigned MAX_REQUEST_LENGTH = 4095;

  localparam int unsigned COUNT_W   = 13;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Mode accepted: add file (suppress bit masked off)
  localparam logic [6:0] MODE_ADD_FILE = 7'h01;

  // Positive response bytes around the block length
  localparam logic [7:0] RESP_FIRST  = 8'h01;
  localparam logic [7:0] RESP_SECOND = 8'h02;
  localparam logic [7:0] RESP_LAST   = 8'h00;

  // Response beats
  localparam logic [2:0] BEAT_FIRST  = 3'd0;
  localparam logic [2:0] BEAT_SECOND = 3'd1;
  localparam logic [2:0] BEAT_HIGH   = 3'd2;
  localparam logic [2:0] BEAT_LOW    = 3'd3;
  localparam logic [2:0] BEAT_LAST   = 3'd4;

  // Verdict queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QLVL_W      = $clog2(QUEUE_DEPTH + 1);

  // Register map
  localparam logic REG_MAX_BLOCK_LENGTH = 1'b0;
  localparam logic [15:0] MAX_BLOCK_LENGTH_RESET = 16'd4095;

  // Verdict of one request, from parser to responder
  typedef struct packed {
    logic    valid;
    status_t status;
  } verdict_t;

  // Queue status, from responder to parser
  typedef struct packed {
    logic [QLVL_W-1:0] level;
  } queue_status_t;

endpackage

FILE: hw/rtl/ftrc_parse.sv
// ----------------------------------------------------------------------------
// ftrc_parse
// Request byte register, field capture and final-byte judgment.
// ----------------------------------------------------------------------------
module ftrc_parse (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             request_byte,
  input  logic                   final_byte,
  input  logic                   programming_session,
  input  logic                   security_level_two,
  input  ftrc_pkg::queue_status_t queue_status,
  output ftrc_pkg::verdict_t     verdict
);

  // Input register
  logic       item;
  logic [7:0] req;
  logic       fin;
  logic       sess;
  logic       sec;

  // Request state
  logic [ftrc_pkg::COUNT_W-1:0] byte_count;
  logic [15:0]                  name_length;
  logic [7:0]                   mode_byte;
  logic [7:0]                   size_field_length;
  logic [31:0]                  uncompressed_size;
  logic [31:0]                  compressed_size;

  logic [ftrc_pkg::COUNT_W-1:0] byte_count_next;
  logic [15:0]                  name_length_next;
  logic [7:0]                   mode_byte_next;
  logic [7:0]                   size_field_length_next;
  logic [31:0]                  uncompressed_size_next;
  logic [31:0]                  compressed_size_next;

  logic                         fresh;
  logic [15:0]                  name_cur;
  logic [7:0]                   mode_cur;
  logic [7:0]                   sfl_cur;
  logic [31:0]                  usize_cur;
  logic [31:0]                  csize_cur;
  logic [ftrc_pkg::COUNT_W-1:0] q;
  logic [ftrc_pkg::COUNT_W-1:0] r;
  logic [ftrc_pkg::COUNT_W:0]   r_ext;
  logic [ftrc_pkg::COUNT_W:0]   usize_end;
  logic [ftrc_pkg::COUNT_W:0]   csize_end;
  logic [17:0]                  len;
  logic [17:0]                  n;
  logic [17:0]                  s2;
  logic [ftrc_pkg::QLVL_W:0]    pending;
  ftrc_pkg::status_t            status;

  // Hold off while every queue slot is taken or promised to the byte in flight
  assign pending  = {1'b0, queue_status.level} +
                    {{ftrc_pkg::QLVL_W{1'b0}}, item & fin};
  assign in_stall = (pending >= (ftrc_pkg::QLVL_W+1)'(ftrc_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      item <= 1'b0;
    end else begin
      item <= in_valid & ~in_stall;
    end
    req  <= request_byte;
    fin  <= final_byte;
    sess <= programming_session;
    sec  <= security_level_two;
  end

  // Field capture; the first byte of a request starts from cleared state
  always_comb begin
    fresh     = (byte_count == '0);
    name_cur  = fresh ? '0 : name_length;
    mode_cur  = fresh ? '0 : mode_byte;
    sfl_cur   = fresh ? '0 : size_field_length;
    usize_cur = fresh ? '0 : uncompressed_size;
    csize_cur = fresh ? '0 : compressed_size;

    q         = byte_count - ftrc_pkg::COUNT_W'(4);
    r         = q - name_cur[ftrc_pkg::COUNT_W-1:0];
    r_ext     = {1'b0, r};
    usize_end = (ftrc_pkg::COUNT_W+1)'(2) + {6'b0, sfl_cur};
    csize_end = (ftrc_pkg::COUNT_W+1)'(2) + {5'b0, sfl_cur, 1'b0};

    name_length_next       = name_cur;
    mode_byte_next         = mode_cur;
    size_field_length_next = sfl_cur;
    uncompressed_size_next = usize_cur;
    compressed_size_next   = csize_cur;

    if (byte_count == ftrc_pkg::COUNT_W'(1)) begin
      mode_byte_next = req;
    end else if (byte_count == ftrc_pkg::COUNT_W'(2)) begin
      name_length_next = {req, name_cur[7:0]};
    end else if (byte_count == ftrc_pkg::COUNT_W'(3)) begin
      name_length_next = {name_cur[15:8], req};
    end else if (byte_count >= ftrc_pkg::COUNT_W'(4)) begin
      // filename bytes are only counted past; nothing downstream reads them
      if ({3'b0, q} >= name_cur) begin
        if (r == ftrc_pkg::COUNT_W'(1)) begin
          size_field_length_next = req;
        end else if (r_ext >= (ftrc_pkg::COUNT_W+1)'(2) && r_ext < usize_end) begin
          uncompressed_size_next = {usize_cur[23:0], req};
        end else if (r_ext >= usize_end && r_ext < csize_end) begin
          compressed_size_next = {csize_cur[23:0], req};
        end
      end
    end

    if (fin) begin
      byte_count_next = '0;
    end else if (byte_count == ftrc_pkg::COUNT_MAX) begin
      byte_count_next = byte_count;
    end else begin
      byte_count_next = byte_count + ftrc_pkg::COUNT_W'(1);
    end
  end

  // Judgment in request order, on the state that includes the final byte
  always_comb begin
    len = 18'(byte_count) + 18'd1;
    n   = {2'b0, name_length_next};
    s2  = {9'b0, size_field_length_next, 1'b0};

    if (byte_count == ftrc_pkg::COUNT_MAX ||
        len > 18'(ftrc_pkg::MAX_REQUEST_LENGTH)) begin
      status = ftrc_pkg::ST_LENGTH;
    end else if (len < 18'd4) begin
      status = ftrc_pkg::ST_LENGTH;
    end else if (len < n + 18'd4) begin
      status = ftrc_pkg::ST_LENGTH;
    end else if (n == '0 || n > 18'(ftrc_pkg::NAME_CAPACITY)) begin
      status = ftrc_pkg::ST_RANGE;
    end else if (mode_byte_next[6:0] != ftrc_pkg::MODE_ADD_FILE) begin
      status = ftrc_pkg::ST_RANGE;
    end else if (len <= n + 18'd6) begin
      status = ftrc_pkg::ST_LENGTH;
    end else if (size_field_length_next == 8'd0 || size_field_length_next > 8'd4) begin
      status = ftrc_pkg::ST_RANGE;
    end else if (len != n + 18'd6 + s2) begin
      status = ftrc_pkg::ST_LENGTH;
    end else if (uncompressed_size_next == '0 || compressed_size_next == '0) begin
      status = ftrc_pkg::ST_RANGE;
    end else if (!sess) begin
      status = ftrc_pkg::ST_SESSION;
    end else if (!sec) begin
      status = ftrc_pkg::ST_SECURITY;
    end else begin
      status = ftrc_pkg::ST_OK;
    end
  end

  assign verdict.valid  = item & fin;
  assign verdict.status = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count        <= '0;
      name_length       <= '0;
      mode_byte         <= '0;
      size_field_length <= '0;
      uncompressed_size <= '0;
      compressed_size   <= '0;
    end else if (item) begin
      byte_count        <= byte_count_next;
      name_length       <= name_length_next;
      mode_byte         <= mode_byte_next;
      size_field_length <= size_field_length_next;
      uncompressed_size <= uncompressed_size_next;
      compressed_size   <= compressed_size_next;
    end
  end

endmodule

FILE: hw/rtl/ftrc_resp.sv
// ----------------------------------------------------------------------------
// ftrc_resp
// Verdict queue and response sequencer with registered result output.
// ----------------------------------------------------------------------------
module ftrc_resp (
  input  logic                    clk,
  input  logic                    rst,
  input  ftrc_pkg::verdict_t      verdict,
  output ftrc_pkg::queue_status_t queue_status,
  input  logic [15:0]             max_block_length,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              status,
  output logic [7:0]              response_byte,
  output logic                    byte_present,
  output logic                    start_transfer,
  output logic                    final_result
);

  ftrc_pkg::status_t queue [ftrc_pkg::QUEUE_DEPTH];
  logic [ftrc_pkg::QPTR_W-1:0] wr_ptr;
  logic [ftrc_pkg::QPTR_W-1:0] rd_ptr;
  logic [ftrc_pkg::QLVL_W-1:0] level;
  logic [2:0]                  beat;

  ftrc_pkg::status_t head;
  logic              load;
  logic              pop;
  logic              push;
  logic [7:0]        byte_sel;
  logic              last_beat;

  assign head      = queue[rd_ptr];
  assign push      = verdict.valid;
  assign load      = (level != '0) && (!out_valid || !out_stall);
  assign last_beat = (head != ftrc_pkg::ST_OK) || (beat == ftrc_pkg::BEAT_LAST);
  assign pop       = load && last_beat;

  assign queue_status.level = level;

  always_comb begin
    case (beat)
      ftrc_pkg::BEAT_FIRST:  byte_sel = ftrc_pkg::RESP_FIRST;
      ftrc_pkg::BEAT_SECOND: byte_sel = ftrc_pkg::RESP_SECOND;
      ftrc_pkg::BEAT_HIGH:   byte_sel = max_block_length[15:8];
      ftrc_pkg::BEAT_LOW:    byte_sel = max_block_length[7:0];
      default:               byte_sel = ftrc_pkg::RESP_LAST;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= verdict.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
      beat   <= ftrc_pkg::BEAT_FIRST;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level + ftrc_pkg::QLVL_W'(push) - ftrc_pkg::QLVL_W'(pop);
      if (pop) begin
        beat <= ftrc_pkg::BEAT_FIRST;
      end else if (load) begin
        beat <= beat + 3'd1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      status         <= head;
      response_byte  <= (head == ftrc_pkg::ST_OK) ? byte_sel : 8'h00;
      byte_present   <= (head == ftrc_pkg::ST_OK);
      start_transfer <= (head == ftrc_pkg::ST_OK) && (beat == ftrc_pkg::BEAT_LAST);
      final_result   <= last_beat;
    end
  end

endmodule

FILE: hw/rtl/file_transfer_request_checker_top.sv
// ----------------------------------------------------------------------------
// file_transfer_request_checker_top
// Path: a final request byte passes the input register, verdict queue and
//   result register. Throughput: one request byte per cycle unless in_stall,
//   one result per cycle unless out_stall; each accepted add-file request gives
//   five result transfers, paced by the output register and a four-entry queue.
// Reset (synchronous, active high): request state cleared, queue emptied,
//   max_block_length back to 4095.
// ----------------------------------------------------------------------------
module file_transfer_request_checker_top (
  input  logic        clk,
  input  logic        rst,

  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  // Request byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  request_byte,
  input  logic        final_byte,
  input  logic        programming_session,
  input  logic        security_level_two,

  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  response_byte,
  output logic        byte_present,
  output logic        start_transfer,
  output logic        final_result
);

  logic [15:0]             max_block_length;
  logic                    cfg_write;
  ftrc_pkg::verdict_t      verdict;
  ftrc_pkg::queue_status_t queue_status;

  // Register file: one 16-bit register, word aligned
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready &
                     (paddr[2] == ftrc_pkg::REG_MAX_BLOCK_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_block_length <= ftrc_pkg::MAX_BLOCK_LENGTH_RESET;
    end else if (cfg_write) begin
      max_block_length <= pwdata[15:0];
    end
  end

  // Read back the register at its address, zero elsewhere
  always_comb begin
    if (paddr[2] == ftrc_pkg::REG_MAX_BLOCK_LENGTH) begin
      prdata = {16'b0, max_block_length};
    end else begin
      prdata = '0;
    end
  end

  // Capture fields byte by byte and judge at the final byte
  ftrc_parse u_parse (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .request_byte        (request_byte),
    .final_byte          (final_byte),
    .programming_session (programming_session),
    .security_level_two  (security_level_two),
    .queue_status        (queue_status),
    .verdict             (verdict)
  );

  // Queue verdicts and expand each into its result transfers
  ftrc_resp u_resp (
    .clk              (clk),
    .rst              (rst),
    .verdict          (verdict),
    .queue_status     (queue_status),
    .max_block_length (max_block_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .response_byte    (response_byte),
    .byte_present     (byte_present),
    .start_transfer   (start_transfer),
    .final_result     (final_result)
  );

endmodule

FILE: sim/tb_file_transfer_request_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_file_transfer_request_checker_top
// Feeds RequestFileTransfer requests into the checker one byte per transfer
// and compares every result transfer against a cycle-free predictor of the
// request parser and its verdict rules. A short directed table covers the
// extremes and error codes, then random requests run in four idling phases,
// each under its own max_block_length setting.
// ----------------------------------------------------------------------------
module tb_file_transfer_request_checker_top;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned PHASE_BYTES    = 68;
  localparam logic [2:0]  BLOCK_LENGTH_ADDR = 3'(4 * ftrc_pkg::REG_MAX_BLOCK_LENGTH);
  localparam logic [7:0]  SERVICE_ID     = 8'h38;
  localparam logic [7:0]  MODE_ADD       = 8'h01;
  localparam logic [7:0]  MODE_ADD_QUIET = 8'h81;

  // One expected result transfer
  typedef struct {
    ftrc_pkg::status_t st;
    logic [7:0]        data;
    logic              present;
    logic              start;
    logic              last;
  } result_t;

  // One row of the directed table
  typedef struct {
    logic [7:0]        data;
    bit                last;
    bit                session;
    bit                security;
    bit                typed;
    ftrc_pkg::status_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  request_byte = '0;
  logic        final_byte = 1'b0;
  logic        programming_session = 1'b0;
  logic        security_level_two = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [7:0]  response_byte;
  logic        byte_present;
  logic        start_transfer;
  logic        final_result;

  file_transfer_request_checker_top u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .request_byte        (request_byte),
    .final_byte          (final_byte),
    .programming_session (programming_session),
    .security_level_two  (security_level_two),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .status              (status),
    .response_byte       (response_byte),
    .byte_present        (byte_present),
    .start_transfer      (start_transfer),
    .final_result        (final_result)
  );

  // Idling knobs, in percent, changed per phase
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct    = 0;

  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;

  // Results still owed by the block, oldest first
  result_t pending_results[$];

  // Predictor copy of the parser state and the register
  logic [12:0] seen_count;
  logic [15:0] name_len;
  logic [7:0]  mode;
  logic [7:0]  size_len;
  logic [31:0] uncompressed;
  logic [31:0] compressed;
  logic [7:0]  name_bytes [ftrc_pkg::NAME_CAPACITY];
  logic [15:0] block_length;

  // Directed table: the expected status is typed in on error rows, the
  // accepted request is left to the predictor.
  stim_row_t directed_rows [23] = '{
    // Lone service id: request shorter than four bytes
    '{SERVICE_ID, 1'b1, 1'b1, 1'b1, 1'b1, ftrc_pkg::ST_LENGTH},
    // Smallest well-formed add-file request: one name byte, 1-byte sizes
    '{SERVICE_ID, 1'b0, 1'b0, 1'b0, 1'b0, ftrc_pkg::ST_OK},
    '{MODE_ADD,   1'b0, 1'b0, 1'b1, 1'b0, ftrc_pkg::ST_OK},
    '{8'h00,      1'b0, 1'b1, 1'b0, 1'b0, ftrc_pkg::ST_OK},
    '{8'h01,      1'b0, 1'b0, 1'b0, 1'b0, ftrc_pkg::ST_OK},
    '{8'h41,      1'b0, 1'b1, 1'b1, 1'b0, ftrc_pkg::ST_OK},
    '{8'h00,      1'b0, 1'b0, 1'b0, 1'b0, ftrc_pkg::ST_OK},
    '{8'h01,      1'b0, 1'b0, 1'b0, 1'b0, ftrc_pkg::ST_OK},
    '{8'h05,      1'b0, 1'b0, 1'b0, 1'b0, ftrc_pkg::ST_OK},
    '{8'h07,      1'b1, 1'b1, 1'b1, 1'b0, ftrc_pkg::ST_OK},
    // All-ones name length field: 65535 overruns a four-byte request
    '{8'hFF,      1'b0, 1'b1, 1'b1, 1'b0, ftrc_pkg::ST_OK},
    '{MODE_ADD_QUIET, 1'b0, 1'b1, 1'b1, 1'b0, ftrc_pkg::ST_OK},
    '{8'hFF,      1'b0, 1'b1, 1'b1, 1'b0, ftrc_pkg::ST_OK},
    '{8'hFF,      1'b1, 1'b1, 1'b1, 1'b1, ftrc_pkg::ST_LENGTH},
    // Suppress-bit mode, zero uncompressed size: out of range
    '{8'h00,      1'b0, 1'b0, 1'b0, 1'b0, ftrc_pkg::ST_OK},
    '{MODE_ADD_QUIET, 1'b0, 1'b0, 1'b0, 1'b0, ftrc_pkg::ST_OK},
    '{8'h00,      1'b0, 1'b0, 1'b0, 1'b0, ftrc_pkg::ST_OK},
    '{8'h01,      1'b0, 1'b0, 1'b0, 1'b0, ftrc_pkg::ST_OK},
    '{8'hFF,      1'b0, 1'b0, 1'b0, 1'b0, ftrc_pkg::ST_OK},
    '{8'hFF,      1'b0, 1'b0, 1'b0, 1'b0, ftrc_pkg::ST_OK},
    '{8'h01,      1'b0, 1'b0, 1'b0, 1'b0, ftrc_pkg::ST_OK},
    '{8'h00,      1'b0, 1'b0, 1'b0, 1'b0, ftrc_pkg::ST_OK},
    '{8'h01,      1'b1, 1'b0, 1'b0, 1'b1, ftrc_pkg::ST_RANGE}
  };

  initial begin
    forever #10 clk = ~clk;
  end

  // Count a failure; report only the first few in full
  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endfunction

  // Run the verdict rules on a request whose final byte is being absorbed
  function automatic ftrc_pkg::status_t judge_request(input bit sess, input bit sec);
    int unsigned len;
    int unsigned n;
    int unsigned s;
    len = seen_count + 1;
    n   = name_len;
    s   = size_len;
    if (seen_count == ftrc_pkg::COUNT_MAX || len > ftrc_pkg::MAX_REQUEST_LENGTH) begin
      return ftrc_pkg::ST_LENGTH;
    end
    if (len < 4) return ftrc_pkg::ST_LENGTH;
    if (len < n + 4) return ftrc_pkg::ST_LENGTH;
    if (n == 0 || n > ftrc_pkg::NAME_CAPACITY) return ftrc_pkg::ST_RANGE;
    if (mode[6:0] != ftrc_pkg::MODE_ADD_FILE) return ftrc_pkg::ST_RANGE;
    if (len <= n + 6) return ftrc_pkg::ST_LENGTH;
    if (s == 0 || s > 4) return ftrc_pkg::ST_RANGE;
    if (len != n + 6 + 2 * s) return ftrc_pkg::ST_LENGTH;
    if (uncompressed == 0 || compressed == 0) return ftrc_pkg::ST_RANGE;
    if (!sess) return ftrc_pkg::ST_SESSION;
    if (!sec) return ftrc_pkg::ST_SECURITY;
    return ftrc_pkg::ST_OK;
  endfunction

  // Absorb one accepted request byte and return the results it causes
  function automatic void absorb_byte(input logic [7:0] data, input bit last,
                                      input bit sess, input bit sec,
                                      output result_t outcome[$]);
    int unsigned       pos;
    int unsigned       q;
    int unsigned       r;
    ftrc_pkg::status_t st;
    outcome = {};
    // First byte of a request: drop everything left from the previous one
    if (seen_count == 0) begin
      name_len     = '0;
      mode         = '0;
      size_len     = '0;
      uncompressed = '0;
      compressed   = '0;
      foreach (name_bytes[i]) name_bytes[i] = '0;
    end
    pos = seen_count;
    if (pos == 1) begin
      mode = data;
    end else if (pos == 2) begin
      name_len[15:8] = data;
    end else if (pos == 3) begin
      name_len[7:0] = data;
    end else if (pos >= 4) begin
      q = pos - 4;
      if (q < name_len) begin
        if (q < ftrc_pkg::NAME_CAPACITY) name_bytes[q] = data;
      end else begin
        r = q - name_len;
        if (r == 1) begin
          size_len = data;
        end else if (r >= 2 && r < 2 + size_len) begin
          uncompressed = {uncompressed[23:0], data};
        end else if (r >= 2 + size_len && r < 2 + 2 * size_len) begin
          compressed = {compressed[23:0], data};
        end
      end
    end
    if (!last) begin
      if (seen_count != ftrc_pkg::COUNT_MAX) seen_count++;
      return;
    end
    st = judge_request(sess, sec);
    seen_count = '0;
    if (st != ftrc_pkg::ST_OK) begin
      outcome.push_back('{st, 8'h00, 1'b0, 1'b0, 1'b1});
    end else begin
      outcome.push_back('{ftrc_pkg::ST_OK, ftrc_pkg::RESP_FIRST, 1'b1, 1'b0, 1'b0});
      outcome.push_back('{ftrc_pkg::ST_OK, ftrc_pkg::RESP_SECOND, 1'b1, 1'b0, 1'b0});
      outcome.push_back('{ftrc_pkg::ST_OK, block_length[15:8], 1'b1, 1'b0, 1'b0});
      outcome.push_back('{ftrc_pkg::ST_OK, block_length[7:0], 1'b1, 1'b0, 1'b0});
      outcome.push_back('{ftrc_pkg::ST_OK, ftrc_pkg::RESP_LAST, 1'b1, 1'b1, 1'b1});
    end
  endfunction

  // Offer one byte, hold it until the transfer, then queue its results
  task automatic send_byte(input logic [7:0] data, input bit last, input bit sess,
                           input bit sec, input bit typed,
                           input ftrc_pkg::status_t want);
    result_t outcome[$];
    result_t typed_err;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    request_byte        <= data;
    final_byte          <= last;
    programming_session <= sess;
    security_level_two  <= sec;
    do @(posedge clk); while (in_stall);
    absorb_byte(data, last, sess, sec, outcome);
    // Error rows of the table carry their own verdict
    if (typed && last) begin
      typed_err.st      = want;
      typed_err.data    = 8'h00;
      typed_err.present = 1'b0;
      typed_err.start   = 1'b0;
      typed_err.last    = 1'b1;
      outcome.delete();
      outcome.push_back(typed_err);
    end
    foreach (outcome[i]) pending_results.push_back(outcome[i]);
  endtask

  // Wait until every owed result is out, then let the pipeline settle
  task automatic wait_for_drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write max_block_length, then read it back
  task automatic set_block_length(input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BLOCK_LENGTH_ADDR;
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    block_length = value;
    // Go straight from the write access into the read setup
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {16'h0000, value}) begin
      note_failure($sformatf("max_block_length read: expected %h, got %h",
                             {16'h0000, value}, prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Build one random request. A nonzero forced_n gives a well-formed
  // layout with that name length and 4-byte sizes.
  task automatic build_request(input int unsigned forced_n, output logic [7:0] bytes[$]);
    int unsigned roll;
    int unsigned n;
    int unsigned s;
    int unsigned extra;
    bit          zero;
    bytes = {};
    roll  = (forced_n != 0) ? 99 : $urandom_range(99);
    // Noise: a short run of arbitrary bytes
    if (roll < 15) begin
      repeat ($urandom_range(1, 12)) bytes.push_back(8'($urandom));
      return;
    end
    if (forced_n != 0) begin
      n = forced_n;
      s = 4;
    end else begin
      // Mostly short names, now and then up to and past the capacity
      n = ($urandom_range(7) == 0) ? $urandom_range(9, ftrc_pkg::NAME_CAPACITY + 6)
                                   : $urandom_range(1, 8);
      s = $urandom_range(1, 4);
    end
    bytes.push_back(($urandom_range(3) == 0) ? 8'($urandom) : SERVICE_ID);
    if (roll < 25) begin
      bytes.push_back(8'($urandom));
    end else begin
      bytes.push_back($urandom_range(1) ? MODE_ADD_QUIET : MODE_ADD);
    end
    bytes.push_back(8'(n >> 8));
    bytes.push_back(8'(n));
    repeat (n) bytes.push_back(8'($urandom));
    bytes.push_back(8'($urandom));
    if (roll < 35) begin
      bytes.push_back(($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6)));
    end else begin
      bytes.push_back(8'(s));
    end
    // Uncompressed then compressed size; now and then a zero size
    repeat (2) begin
      zero = ($urandom_range(9) == 0);
      repeat (s) bytes.push_back(zero ? 8'h00 : 8'($urandom));
    end
    // Break the length: pad or cut a few bytes
    if (roll >= 35 && roll < 47) begin
      if ($urandom_range(1)) begin
        repeat ($urandom_range(1, 3)) bytes.push_back(8'($urandom));
      end else begin
        extra = $urandom_range(1, 4);
        repeat (extra) begin
          if (bytes.size() > 1) void'(bytes.pop_back());
        end
      end
    end
  endtask

  // Result side: random stall, compare each transfer with the oldest owed
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          note_failure($sformatf("unexpected result: status %0d byte %h present %b start %b last %b",
                                 status, response_byte, byte_present, start_transfer,
                                 final_result));
        end else begin
          want = pending_results.pop_front();
          if (status !== want.st || response_byte !== want.data ||
              byte_present !== want.present || start_transfer !== want.start ||
              final_result !== want.last) begin
            note_failure($sformatf({"result mismatch: expected status %0d byte %h present %b",
                                    " start %b last %b, got status %0d byte %h present %b",
                                    " start %b last %b"},
                                   want.st, want.data, want.present, want.start, want.last,
                                   status, response_byte, byte_present, start_transfer,
                                   final_result));
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: end the run if no transfer happens on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0]  req[$];
    int unsigned phase_bytes;
    int unsigned req_index;
    bit          last;
    seen_count   = '0;
    name_len     = '0;
    mode         = '0;
    size_len     = '0;
    uncompressed = '0;
    compressed   = '0;
    foreach (name_bytes[i]) name_bytes[i] = '0;
    block_length = ftrc_pkg::MAX_BLOCK_LENGTH_RESET;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed table under the reset value of max_block_length, no idling
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].session,
                directed_rows[i].security, directed_rows[i].typed, directed_rows[i].want);
    end
    in_valid <= 1'b0;

    // Random phases: each starts idle, with a fresh register setting
    for (int phase = 0; phase < 4; phase++) begin
      wait_for_drain();
      case (phase)
        0: set_block_length(16'hFFFF);
        1: set_block_length(16'h0000);
        default: set_block_length(16'($urandom));
      endcase
      case (phase)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 85; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 85; end
        default: begin send_gap_pct = 34; stall_pct = 34; end
      endcase
      phase_bytes = 0;
      req_index   = 0;
      while (phase_bytes < PHASE_BYTES) begin
        // Name length right at the capacity, then one past it
        if (phase == 0 && req_index == 2) begin
          build_request(ftrc_pkg::NAME_CAPACITY, req);
        end else if (phase == 0 && req_index == 4) begin
          build_request(ftrc_pkg::NAME_CAPACITY + 1, req);
        end else begin
          build_request(0, req);
        end
        phase_bytes += req.size();
        foreach (req[i]) begin
          last = (i == req.size() - 1);
          // Session and security matter at the final byte: favor unlocked
          send_byte(req[i], last,
                    last ? ($urandom_range(99) < 85) : 1'($urandom_range(1)),
                    last ? ($urandom_range(99) < 85) : 1'($urandom_range(1)),
                    1'b0, ftrc_pkg::ST_OK);
        end
        req_index++;
      end
      in_valid <= 1'b0;
    end

    wait_for_drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/ftrc_pkg.sv
hw/rtl/ftrc_parse.sv
hw/rtl/ftrc_resp.sv
hw/rtl/file_transfer_request_checker_top.sv
sim/tb_file_transfer_request_checker_top.sv
